FILE: sv/brle_pkg.sv
// Shared constants, codes and controller/datapath interface types of the byte RLE encoder.
`default_nettype none

package brle_pkg;

  localparam int BYTE_W       = 8;
  localparam int CNT_W        = 8;
  localparam int TAIL_W       = 2;

  localparam int MIN_RUN      = 3;
  localparam int MAX_RUN      = 130;
  localparam int MAX_LITERALS = 63;
  localparam int RESULT_CAP   = 64;

  localparam int ADDR_W       = $clog2(MAX_LITERALS);
  localparam int EMIT_W       = $clog2(RESULT_CAP);

  localparam logic KIND_HDR  = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  // what goes into the output register on a load
  typedef enum logic [1:0] {
    SRC_HDR,
    SRC_REP,
    SRC_LIT
  } ld_src_t;

  typedef struct packed {
    logic    accept;
    logic    ld_en;
    ld_src_t ld_src;
    logic    grp_b;
    logic    ld_last;
    logic    rd_start;
    logic    rd_next;
  } brle_cmd_t;

  typedef struct packed {
    logic close_a_nxt;
    logic close_b_nxt;
    logic a_rep;
    logic b_rep;
    logic lit_last;
    logic out_free;
  } brle_sts_t;

endpackage

`default_nettype wire

FILE: sv/brle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module brle_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: sv/brle_ctrl.sv
// Controller state machine: input acceptance and sequencing of group headers and bytes.
`default_nettype none

module brle_ctrl import brle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  brle_sts_t sts,
  output brle_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HDR,
    S_REP,
    S_LIT
  } state_t;

  state_t            state_r, state_nxt;
  logic              grp_b_r, grp_b_nxt;
  logic              b_pend_r, b_pend_nxt;
  logic [EMIT_W-1:0] emit_cnt_r, emit_cnt_nxt;

  logic cur_rep;
  logic cap_hit;
  logic more_grp;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    grp_b_nxt    = grp_b_r;
    b_pend_nxt   = b_pend_r;
    emit_cnt_nxt = emit_cnt_r;
    cur_rep      = grp_b_r ? sts.b_rep : sts.a_rep;
    cap_hit      = (emit_cnt_r == EMIT_W'(RESULT_CAP - 1));
    more_grp     = !grp_b_r && b_pend_r;
    cmd.grp_b    = grp_b_r;

    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          emit_cnt_nxt = '0;
          b_pend_nxt   = sts.close_b_nxt;
          if (sts.close_a_nxt) begin
            state_nxt = S_HDR;
            grp_b_nxt = 1'b0;
          end else if (sts.close_b_nxt) begin
            state_nxt = S_HDR;
            grp_b_nxt = 1'b1;
          end
        end
      end
      S_HDR: begin
        cmd.rd_start = 1'b1;
        if (sts.out_free) begin
          cmd.ld_en    = 1'b1;
          cmd.ld_src   = SRC_HDR;
          cmd.ld_last  = cap_hit;
          emit_cnt_nxt = emit_cnt_r + EMIT_W'(1);
          if (cap_hit) begin
            state_nxt = S_IDLE;
          end else if (cur_rep) begin
            state_nxt = S_REP;
          end else begin
            state_nxt = S_LIT;
          end
        end
      end
      S_REP: begin
        if (sts.out_free) begin
          cmd.ld_en    = 1'b1;
          cmd.ld_src   = SRC_REP;
          cmd.ld_last  = cap_hit || !more_grp;
          emit_cnt_nxt = emit_cnt_r + EMIT_W'(1);
          if (cap_hit || !more_grp) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_HDR;
            grp_b_nxt = 1'b1;
          end
        end
      end
      S_LIT: begin
        if (sts.out_free) begin
          cmd.ld_en    = 1'b1;
          cmd.ld_src   = SRC_LIT;
          cmd.ld_last  = cap_hit || (sts.lit_last && !more_grp);
          emit_cnt_nxt = emit_cnt_r + EMIT_W'(1);
          if (cap_hit) begin
            state_nxt = S_IDLE;
          end else if (sts.lit_last) begin
            if (more_grp) begin
              state_nxt = S_HDR;
              grp_b_nxt = 1'b1;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      grp_b_r    <= 1'b0;
      b_pend_r   <= 1'b0;
      emit_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      grp_b_r    <= grp_b_nxt;
      b_pend_r   <= b_pend_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_en |-> sts.out_free)
    else $error("output register loaded while occupied");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_en && cmd.ld_last |=> state_r == S_IDLE)
    else $error("burst continued after its last beat");

  a_quiet_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && !sts.close_a_nxt && !sts.close_b_nxt |=> state_r == S_IDLE)
    else $error("byte with no closed group left the idle state");

endmodule

`default_nettype wire

FILE: sv/brle_dp.sv
// Datapath: group tracking, literal store, flush plan and output register.
`default_nettype none

module brle_dp import brle_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [BYTE_W-1:0]        in_data_byte_in,
  input  logic                     in_end_of_stream,
  input  brle_cmd_t                cmd,
  output brle_sts_t                sts,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_item_kind,
  output logic signed [BYTE_W-1:0] out_header_value,
  output logic [BYTE_W-1:0]        out_data_byte_out,
  output logic                     out_last_of_burst
);

  // open group
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              rep_r, rep_nxt;
  logic [TAIL_W-1:0] tail_r, tail_nxt;
  logic [BYTE_W-1:0] first_r, first_nxt;
  logic [BYTE_W-1:0] last_r, last_nxt;

  // groups closed by the current byte: A inside the byte, B by end of stream
  logic              close_a, close_b;
  logic              a_rep_r, a_rep_nxt, b_rep_r, b_rep_nxt;
  logic [CNT_W-1:0]  a_len_r, a_len_nxt, b_len_r, b_len_nxt;
  logic [BYTE_W-1:0] a_byte_r, a_byte_nxt, b_byte_r, b_byte_nxt;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] rd_idx_r;
  logic [BYTE_W-1:0] rd_data;

  logic [CNT_W-1:0]  cnt_inc;
  logic [TAIL_W-1:0] tail_inc;
  logic [CNT_W-1:0]  cur_len;
  logic              cur_rep;
  logic [BYTE_W-1:0] cur_byte;
  logic [BYTE_W-1:0] hdr_val;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [BYTE_W-1:0] out_hdr_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  always_comb begin
    cnt_inc    = cnt_r + CNT_W'(1);
    tail_inc   = (in_data_byte_in == last_r) ? tail_r + TAIL_W'(1) : TAIL_W'(1);
    cnt_nxt    = cnt_r;
    rep_nxt    = rep_r;
    tail_nxt   = tail_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    close_a    = 1'b0;
    a_rep_nxt  = rep_r;
    a_len_nxt  = cnt_r;
    a_byte_nxt = first_r;
    wr_en      = 1'b0;
    wr_addr    = cnt_r[ADDR_W-1:0];

    if (cnt_r == '0) begin
      wr_en    = 1'b1;
      wr_addr  = '0;
      cnt_nxt  = CNT_W'(1);
      tail_nxt = TAIL_W'(1);
      last_nxt = in_data_byte_in;
    end else if (rep_r) begin
      if (in_data_byte_in == first_r) begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= CNT_W'(MAX_RUN)) begin
          close_a   = 1'b1;
          a_rep_nxt = 1'b1;
          a_len_nxt = cnt_inc;
          cnt_nxt   = '0;
          rep_nxt   = 1'b0;
          tail_nxt  = '0;
        end
      end else begin
        // run broken: close the repeat, the new byte opens a literal group
        close_a   = 1'b1;
        a_rep_nxt = 1'b1;
        a_len_nxt = cnt_r;
        wr_en     = 1'b1;
        wr_addr   = '0;
        cnt_nxt   = CNT_W'(1);
        rep_nxt   = 1'b0;
        tail_nxt  = TAIL_W'(1);
        last_nxt  = in_data_byte_in;
      end
    end else begin
      if (tail_inc == TAIL_W'(MIN_RUN)) begin
        if (cnt_inc == CNT_W'(MIN_RUN)) begin
          // whole group is the run: turn it into a repeat in place
          rep_nxt   = 1'b1;
          cnt_nxt   = cnt_inc;
          first_nxt = in_data_byte_in;
          tail_nxt  = tail_inc;
        end else begin
          // literals before the run go out, the run becomes a repeat
          close_a   = 1'b1;
          a_rep_nxt = 1'b0;
          a_len_nxt = cnt_r - CNT_W'(MIN_RUN - 1);
          first_nxt = in_data_byte_in;
          rep_nxt   = 1'b1;
          cnt_nxt   = CNT_W'(MIN_RUN);
          tail_nxt  = '0;
        end
      end else begin
        tail_nxt = tail_inc;
        wr_en    = 1'b1;
        cnt_nxt  = cnt_inc;
        last_nxt = in_data_byte_in;
        if (cnt_inc >= CNT_W'(MAX_LITERALS)) begin
          close_a   = 1'b1;
          a_rep_nxt = 1'b0;
          a_len_nxt = cnt_inc;
          cnt_nxt   = '0;
          rep_nxt   = 1'b0;
          tail_nxt  = '0;
        end
      end
    end

    close_b    = in_end_of_stream && (cnt_nxt != '0);
    b_rep_nxt  = rep_nxt;
    b_len_nxt  = cnt_nxt;
    b_byte_nxt = first_nxt;
    if (close_b) begin
      cnt_nxt  = '0;
      rep_nxt  = 1'b0;
      tail_nxt = '0;
    end
  end

  // read address keeps rd_data aligned with rd_idx_r
  always_comb begin
    if (cmd.rd_start) begin
      rd_addr = '0;
    end else if (cmd.rd_next) begin
      rd_addr = rd_idx_r + ADDR_W'(1);
    end else begin
      rd_addr = rd_idx_r;
    end
  end

  brle_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_LITERALS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en && cmd.accept),
    .wr_addr (wr_addr),
    .wr_data (in_data_byte_in),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cur_len  = cmd.grp_b ? b_len_r : a_len_r;
  assign cur_rep  = cmd.grp_b ? b_rep_r : a_rep_r;
  assign cur_byte = cmd.grp_b ? b_byte_r : a_byte_r;
  assign hdr_val  = cur_rep ? (cur_len - CNT_W'(MIN_RUN)) : (CNT_W'(0) - cur_len);

  always_comb begin
    sts             = '0;
    sts.close_a_nxt = close_a;
    sts.close_b_nxt = close_b;
    sts.a_rep       = a_rep_r;
    sts.b_rep       = b_rep_r;
    sts.lit_last    = (CNT_W'(rd_idx_r) == cur_len - CNT_W'(1));
    sts.out_free    = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rep_r  <= 1'b0;
      tail_r <= '0;
    end else if (cmd.accept) begin
      cnt_r  <= cnt_nxt;
      rep_r  <= rep_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      first_r  <= first_nxt;
      last_r   <= last_nxt;
      a_rep_r  <= a_rep_nxt;
      a_len_r  <= a_len_nxt;
      a_byte_r <= a_byte_nxt;
      b_rep_r  <= b_rep_nxt;
      b_len_r  <= b_len_nxt;
      b_byte_r <= b_byte_nxt;
    end
    rd_idx_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_en) begin
      out_last_r <= cmd.ld_last;
      case (cmd.ld_src)
        SRC_REP: begin
          out_kind_r <= KIND_BYTE;
          out_hdr_r  <= '0;
          out_byte_r <= cur_byte;
        end
        SRC_LIT: begin
          out_kind_r <= KIND_BYTE;
          out_hdr_r  <= '0;
          out_byte_r <= rd_data;
        end
        default: begin
          out_kind_r <= KIND_HDR;
          out_hdr_r  <= hdr_val;
          out_byte_r <= '0;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_item_kind     = out_kind_r;
  assign out_header_value  = $signed(out_hdr_r);
  assign out_data_byte_out = out_byte_r;
  assign out_last_of_burst = out_last_r;

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(MAX_RUN))
    else $error("open group longer than the maximum run");

  a_lit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !rep_r |-> cnt_r < CNT_W'(MAX_LITERALS))
    else $error("literal group reached the store depth while open");

  a_rep_min: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r |-> cnt_r >= CNT_W'(MIN_RUN))
    else $error("repeat group shorter than the minimum run");

endmodule

`default_nettype wire

FILE: sv/byte_run_length_encoder.sv
// Top level of the byte run-length encoder: controller plus datapath.
`default_nettype none

// A byte that closes no group leaves the controller idle: such bytes stream at one per
// cycle. A byte that closes one or two groups (run break, run after literals, full group,
// or end of stream) is accepted, then keeps in_stall high while its result beats go out:
// the header, then the repeated byte or every stored literal, and while out_stall holds
// the one-entry output register. Literals sit in a 63-entry RAM and are read back
// through its registered read port in step with the output register, one per cycle while
// it is free. A burst is at most 64 beats; last_of_burst marks the final beat of a byte.
module byte_run_length_encoder import brle_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BYTE_W-1:0]        in_data_byte_in,
  input  logic                     in_end_of_stream,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_item_kind,
  output logic signed [BYTE_W-1:0] out_header_value,
  output logic [BYTE_W-1:0]        out_data_byte_out,
  output logic                     out_last_of_burst
);

  brle_cmd_t cmd;
  brle_sts_t sts;

  brle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  brle_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_data_byte_in   (in_data_byte_in),
    .in_end_of_stream  (in_end_of_stream),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item_kind     (out_item_kind),
    .out_header_value  (out_header_value),
    .out_data_byte_out (out_data_byte_out),
    .out_last_of_burst (out_last_of_burst)
  );

endmodule

`default_nettype wire

FILE: tb/tb_byte_run_length_encoder.sv
// Self-checking testbench for the byte run-length encoder: directed plus randomized streams.
`timescale 1ns / 1ps

module tb_byte_run_length_encoder import brle_pkg::*; ();

  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic                     kind;
    logic signed [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0]        data;
    logic                     last;
  } rle_beat_t;

  // Tracks the open group the same way the encoder does and queues the beats it owes.
  class rle_scoreboard;
    logic [BYTE_W-1:0] lit_store [MAX_LITERALS];
    int unsigned       held;
    bit                repeat_grp;
    bit [TAIL_W-1:0]   tail_run;
    rle_beat_t         burst[$];
    rle_beat_t         expected[$];
    int unsigned       errors;
    int unsigned       bytes_seen;
    int unsigned       beats_seen;

    function new();
      foreach (lit_store[i]) lit_store[i] = '0;
      held       = 0;
      repeat_grp = 1'b0;
      tail_run   = '0;
      errors     = 0;
      bytes_seen = 0;
      beats_seen = 0;
    endfunction

    function void push_beat(logic kind, logic [BYTE_W-1:0] hdr, logic [BYTE_W-1:0] data);
      rle_beat_t b;
      if (burst.size() < RESULT_CAP) begin
        b.kind = kind;
        b.hdr  = hdr;
        b.data = data;
        b.last = 1'b0;
        burst.push_back(b);
      end
    endfunction

    function void close_group();
      if (held == 0) return;
      if (repeat_grp) begin
        push_beat(KIND_HDR, BYTE_W'(held - MIN_RUN), '0);
        push_beat(KIND_BYTE, '0, lit_store[0]);
      end else begin
        push_beat(KIND_HDR, BYTE_W'(0 - held), '0);
        for (int i = 0; i < held && i < MAX_LITERALS; i++)
          push_beat(KIND_BYTE, '0, lit_store[i]);
      end
      repeat_grp = 1'b0;
      tail_run   = '0;
      held       = 0;
    endfunction

    function void store_literal(logic [BYTE_W-1:0] v);
      if (held < MAX_LITERALS) begin
        lit_store[held] = v;
        held++;
      end
    endfunction

    function void take_byte(logic [BYTE_W-1:0] v);
      int unsigned last_idx;
      if (held == 0) begin
        store_literal(v);
        tail_run = 1;
      end else if (repeat_grp) begin
        if (v == lit_store[0]) begin
          held++;
          if (held >= MAX_RUN) close_group();
        end else begin
          close_group();
          store_literal(v);
          tail_run = 1;
        end
      end else begin
        last_idx = held - 1;
        if (last_idx < MAX_LITERALS && v == lit_store[last_idx])
          tail_run = tail_run + 1'b1;
        else
          tail_run = 1;
        if (tail_run == MIN_RUN) begin
          if (held + 1 == MIN_RUN) begin
            repeat_grp = 1'b1;
            held++;
          end else begin
            // the equal tail moves out of the literals into a fresh repeat group
            held -= MIN_RUN - 1;
            close_group();
            lit_store[0] = v;
            repeat_grp   = 1'b1;
            held         = MIN_RUN;
          end
        end else begin
          store_literal(v);
          if (held >= MAX_LITERALS) close_group();
        end
      end
    endfunction

    function void note_input(logic [BYTE_W-1:0] v, logic eos);
      burst.delete();
      take_byte(v);
      if (eos) close_group();
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) expected.push_back(burst[i]);
      bytes_seen++;
    endfunction

    function void check_result(logic kind, logic signed [BYTE_W-1:0] hdr,
                               logic [BYTE_W-1:0] data, logic last);
      rle_beat_t e;
      beats_seen++;
      if (expected.size() == 0) begin
        $error("unexpected beat: item_kind %0d header_value %0d data_byte_out 0x%02h",
               kind, $signed(hdr), data);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (kind !== e.kind) begin
        $error("item_kind: expected %0d, got %0d", e.kind, kind);
        errors++;
      end
      if (hdr !== e.hdr) begin
        $error("header_value: expected %0d, got %0d", $signed(e.hdr), $signed(hdr));
        errors++;
      end
      if (data !== e.data) begin
        $error("data_byte_out: expected 0x%02h, got 0x%02h", e.data, data);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_of_burst: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [BYTE_W-1:0]        in_data_byte_in = '0;
  logic                     in_end_of_stream = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_item_kind;
  logic signed [BYTE_W-1:0] out_header_value;
  logic [BYTE_W-1:0]        out_data_byte_out;
  logic                     out_last_of_burst;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  rle_scoreboard sb = new();

  byte_run_length_encoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte_in   (in_data_byte_in),
    .in_end_of_stream  (in_end_of_stream),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item_kind     (out_item_kind),
    .out_header_value  (out_header_value),
    .out_data_byte_out (out_data_byte_out),
    .out_last_of_burst (out_last_of_burst)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // input beats are noted before result beats are checked in the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data_byte_in, in_end_of_stream);
      if (out_valid && !out_stall)
        sb.check_result(out_item_kind, out_header_value, out_data_byte_out, out_last_of_burst);
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // entered and left at a falling edge
  task automatic send_byte(logic [BYTE_W-1:0] v, logic eos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte_in  <= v;
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // mix of runs, literal stretches and single noise bytes
  task automatic send_random_stream(int target);
    int                sent;
    int                sel;
    int                len;
    logic              eos_end;
    logic [BYTE_W-1:0] v;
    logic [BYTE_W-1:0] prev;
    sent = 0;
    prev = '0;
    while (sent < target) begin
      sel     = $urandom_range(0, 9);
      eos_end = ($urandom_range(0, 2) == 0);
      if (sel <= 3) begin
        v   = BYTE_W'($urandom);
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(120, 135) : $urandom_range(1, 8);
        if (len > target - sent) len = target - sent;
        for (int i = 0; i < len; i++)
          send_byte(v, (i == len - 1) ? eos_end : ($urandom_range(0, 39) == 0));
        prev = v;
      end else if (sel <= 6) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
        if (len > target - sent) len = target - sent;
        for (int i = 0; i < len; i++) begin
          v = ($urandom_range(0, 3) == 0) ? prev : BYTE_W'($urandom);
          send_byte(v, (i == len - 1) ? eos_end : ($urandom_range(0, 39) == 0));
          prev = v;
        end
      end else begin
        len = 1;
        v   = BYTE_W'($urandom);
        send_byte(v, 1'($urandom_range(0, 1)));
        prev = v;
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single-byte literal groups at both byte extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // minimum run from an empty group
    send_byte(8'h05, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h05, 1'b1);
    // literals cut by a run, then the run broken with a flush on the same beat
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h09, 1'b1);
    // equal pair stays literal
    send_byte(8'h04, 1'b0);
    send_byte(8'h04, 1'b1);
    // longer repeat broken by a new byte, no flush, so the break alone emits
    send_byte(8'h03, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(8'h08, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);

    send_random_stream(77);
    send_idle_pct  = 55;
    send_random_stream(77);
    send_idle_pct  = 0;
    recv_stall_pct = 55;
    send_random_stream(77);
    send_idle_pct  = 33;
    recv_stall_pct = 33;
    send_random_stream(77);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("encoded %0d input bytes into %0d checked beats", sb.bytes_seen, sb.beats_seen);
    $display("streams mixed runs, literal stretches and flushes under four idle/stall mixes");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[byte_run_length_encoder] OK");
    end else begin
      $display("[byte_run_length_encoder] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d beats still owed", sb.pending());
    $display("[byte_run_length_encoder] ERROR");
    $finish;
  end

endmodule

FILE: files.f
sv/brle_pkg.sv
sv/brle_ram.sv
sv/brle_ctrl.sv
sv/brle_dp.sv
sv/byte_run_length_encoder.sv
tb/tb_byte_run_length_encoder.sv
